// ===== hw/rtl/ssf_pkg.sv =====
package ssf_pkg;

  // Depth of the frame queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Number of bytes in one position and range frame.
  localparam int unsigned FRAME_BYTES = 4;
  localparam int unsigned BIDX_W      = $clog2(FRAME_BYTES);

  // Reset values of the sweep state and the limit register.
  localparam logic [3:0] STEP_RESET  = 4'd5;
  localparam logic [5:0] POS_RESET   = 6'd32;
  localparam logic [5:0] LIMIT_RESET = 6'd63;

  // Half-step index wrap points.
  localparam logic [3:0] STEP_ABOVE = 4'd9;
  localparam logic [3:0] STEP_BELOW = 4'd0;
  localparam logic [3:0] STEP_FIRST = 4'd1;
  localparam logic [3:0] STEP_LAST  = 4'd8;

  // Marker bit of the range bytes.
  localparam logic MARK = 1'b1;

  // Kind of an input transaction.
  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // One frame as it travels from the front to the back.
  typedef struct packed {
    logic [3:0]                        coils;
    logic [FRAME_BYTES-1:0][7:0]       bytes;
  } frame_t;

  // Half-step coil drive sequence.
  function automatic logic [3:0] coil_lookup(input logic [2:0] idx);
    logic [3:0] pat;
    unique case (idx)
      3'd0: pat = 4'b0101;
      3'd1: pat = 4'b0001;
      3'd2: pat = 4'b1001;
      3'd3: pat = 4'b1000;
      3'd4: pat = 4'b1010;
      3'd5: pat = 4'b0010;
      3'd6: pat = 4'b0110;
      3'd7: pat = 4'b0100;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/ssf_front.sv =====
module ssf_front
  import ssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [5:0]  cfg_position_limit,
  input  logic        in_push,
  input  logic        in_full,
  input  logic        in_kind,
  input  logic        in_sample_slot,
  input  logic [15:0] in_sonar_value,
  input  logic [11:0] in_lidar_value,
  output logic        q_push,
  output frame_t      q_data
);

  logic [5:0]  limit_r;
  logic [3:0]  step_r, step_nxt;
  logic        dir_up_r, dir_up_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] sonar_r [2];
  logic [11:0] lidar_r [2];

  logic        accept;
  logic        tick;
  logic        sample;
  logic [3:0]  step_wrapped;
  logic [3:0]  step_less;
  logic [16:0] sonar_sum;
  logic [12:0] lidar_sum;
  logic [15:0] sonar_avg;
  logic [11:0] lidar_avg;

  assign accept = in_push && !in_full;
  assign tick   = accept && (kind_t'(in_kind) == KIND_TICK);
  assign sample = accept && (kind_t'(in_kind) == KIND_SAMPLE);

  // Wrap the half-step index back into the eight-step sequence.
  always_comb begin
    if (step_r == STEP_ABOVE) begin
      step_wrapped = STEP_FIRST;
    end else if (step_r == STEP_BELOW) begin
      step_wrapped = STEP_LAST;
    end else begin
      step_wrapped = step_r;
    end
    step_less = step_wrapped - 4'd1;
  end

  // Move position and step index together and reverse at either end.
  always_comb begin
    if (dir_up_r) begin
      pos_nxt  = pos_r + 6'd1;
      step_nxt = step_wrapped + 4'd1;
    end else begin
      pos_nxt  = pos_r - 6'd1;
      step_nxt = step_less;
    end
    dir_up_nxt = dir_up_r ^ ((pos_nxt == limit_r) || (pos_nxt == 6'd0));
  end

  // Two-sample averages, truncating.
  assign sonar_sum = {1'b0, sonar_r[0]} + {1'b0, sonar_r[1]};
  assign lidar_sum = {1'b0, lidar_r[0]} + {1'b0, lidar_r[1]};
  assign sonar_avg = sonar_sum[16:1];
  assign lidar_avg = lidar_sum[12:1];

  // Build the frame for the queue.
  always_comb begin
    q_data.coils    = coil_lookup(step_less[2:0]);
    q_data.bytes[0] = {2'b00, pos_nxt};
    q_data.bytes[1] = {MARK, sonar_avg[8:2]};
    q_data.bytes[2] = {MARK, sonar_avg[1:0], lidar_avg[11:7]};
    q_data.bytes[3] = {MARK, lidar_avg[6:0]};
  end

  assign q_push = tick;

  // Sweep state, limit register and sample slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LIMIT_RESET;
      step_r     <= STEP_RESET;
      dir_up_r   <= 1'b1;
      pos_r      <= POS_RESET;
      sonar_r[0] <= '0;
      sonar_r[1] <= '0;
      lidar_r[0] <= '0;
      lidar_r[1] <= '0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_position_limit;
      end
      if (tick) begin
        step_r   <= step_nxt;
        dir_up_r <= dir_up_nxt;
        pos_r    <= pos_nxt;
      end
      if (sample) begin
        sonar_r[in_sample_slot] <= in_sonar_value;
        lidar_r[in_sample_slot] <= in_lidar_value;
      end
    end
  end

endmodule

// ===== hw/rtl/ssf_queue.sv =====
module ssf_queue
  import ssf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output frame_t pop_data
);

  frame_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  logic do_push;
  logic do_pop;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Frame storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ssf_back.sv =====
module ssf_back
  import ssf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  frame_t     q_data,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [3:0] out_coil_pattern,
  output logic [7:0] out_frame_byte,
  output logic       out_last
);

  frame_t            cur_r;
  logic              valid_r;
  logic [BIDX_W-1:0] idx_r;

  logic taken;
  logic at_last;

  assign at_last = (idx_r == BIDX_W'(FRAME_BYTES - 1));
  assign taken   = out_pop && valid_r;
  // Load the next frame when nothing is shown or its last byte leaves now.
  assign q_pop   = !q_empty && (!valid_r || (taken && at_last));

  assign out_empty        = !valid_r;
  assign out_coil_pattern = cur_r.coils;
  assign out_frame_byte   = cur_r.bytes[idx_r];
  assign out_last         = at_last;

  // Current frame register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  // Byte counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (q_pop) begin
        valid_r <= 1'b1;
        idx_r   <= '0;
      end else if (taken) begin
        if (at_last) begin
          valid_r <= 1'b0;
          idx_r   <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/sweep_stepper_sensor_framer.sv =====
// Scanning sensor head framer. Sample transactions (kind 1) store a sonar and
// lidar reading pair into slot 0 or 1 and produce no output. Motor tick
// transactions (kind 0) advance the half-step sequence and the sweep position
// and produce four output transactions: position, then the two-sample
// averages of sonar and lidar packed into 7-bit groups, with last on the
// fourth byte and the tick's coil pattern on all four. The input side takes
// one transaction per cycle while the four-entry frame queue has room; the
// output side delivers one byte per cycle while out_pop is high. A tick's
// frame is written into the frame queue and then loaded into the back's
// frame register before its first byte is on the output ports. The limit
// register is always ready and is written whenever cfg_valid is high.
module sweep_stepper_sensor_framer
  import ssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_position_limit,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic        in_sample_slot,
  input  logic [15:0] in_sonar_value,
  input  logic [11:0] in_lidar_value,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [3:0]  out_coil_pattern,
  output logic [7:0]  out_frame_byte,
  output logic        out_last
);

  logic   q_push;
  frame_t q_in;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  frame_t q_out;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  // Front: classifies transactions and builds frames.
  ssf_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_position_limit (cfg_position_limit),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_kind            (in_kind),
    .in_sample_slot     (in_sample_slot),
    .in_sonar_value     (in_sonar_value),
    .in_lidar_value     (in_lidar_value),
    .q_push             (q_push),
    .q_data             (q_in)
  );

  // Frame queue between front and back.
  ssf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  // Back: serializes each frame one byte per transaction.
  ssf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_coil_pattern (out_coil_pattern),
    .out_frame_byte   (out_frame_byte),
    .out_last         (out_last)
  );

endmodule

// ===== hw/rtl/ssf_checker.sv =====
module ssf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_pop,
  input logic       out_empty,
  input logic [3:0] out_coil_pattern,
  input logic [7:0] out_frame_byte,
  input logic       out_last
);

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  // A stalled output transaction holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_frame_byte)
      && $stable(out_last) && $stable(out_coil_pattern)))
    else $error("stalled output changed");

  // The bytes of one frame follow without gaps and share one coil pattern.
  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=>
      (!out_empty && $stable(out_coil_pattern)))
    else $error("frame broken between bytes");

  // The last byte carries the marker bit and the pattern drives one or two coils.
  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> (out_frame_byte[7] &&
      ($countones(out_coil_pattern) == 1 || $countones(out_coil_pattern) == 2)))
    else $error("bad last byte or coil pattern");

endmodule

bind sweep_stepper_sensor_framer ssf_checker u_ssf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_pop          (out_pop),
  .out_empty        (out_empty),
  .out_coil_pattern (out_coil_pattern),
  .out_frame_byte   (out_frame_byte),
  .out_last         (out_last)
);
